>>> hdl/vpv_pkg.sv
// Shared types and constants of the vertex projection and viewport block.
package vpv_pkg;

    localparam int QUO_BITS = 21;
    localparam int VTX_BITS = 16;
    localparam int ROW_BITS = 64;
    localparam int VIEW_BITS = 13;
    localparam int SCR_BITS = 20;
    localparam int DEPTH_BITS = 16;

    typedef enum logic [2:0] {
        CFG_ROW_X = 3'd0,
        CFG_ROW_Y = 3'd1,
        CFG_ROW_Z = 3'd2,
        CFG_ROW_W = 3'd3,
        CFG_VIEW_W = 3'd4,
        CFG_VIEW_H = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic valid;
        logic wz;
        logic neg_x;
        logic neg_y;
        logic neg_z;
    } side_t;

endpackage

>>> hdl/vertex_projection_viewport_top.sv
// Top level of the vertex transform, perspective divide and viewport mapping block.
//
// Usage:
//   Input channel (in_valid / in_ready) carries one vertex word: vertex_x,
//   vertex_y, vertex_z in signed Q4.12, w taken as 1. Output channel
//   (out_valid / out_ready) returns one word per vertex: screen_x and
//   screen_y in Q16.4 pixels, depth in Q4.12, all saturated, and w_is_zero.
//   Configuration: cfg_we with cfg_index and cfg_data writes a matrix row
//   (indexes 0..3) or the viewport width / height (4, 5); other indexes are
//   dropped. Write only while the pipeline is empty.
// Throughput: one vertex per cycle while out_ready stays high.
// Pipeline from acceptance to out_valid: products, row sums, numerator
//   multiply, magnitude, 22 divider stages (the first checks overflow, each
//   later one sets one quotient bit), and the output register.
// Reset: clears all valid bits; the matrix returns to identity and the
//   viewport to 500 x 500.
// Stall: when out_ready is low with a word waiting, the whole pipeline
//   holds and in_ready drops; nothing is lost or repeated.
module vertex_projection_viewport_top #(
    parameter int COEF_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [vpv_pkg::VTX_BITS-1:0]   vertex_x,
    input  logic signed [vpv_pkg::VTX_BITS-1:0]   vertex_y,
    input  logic signed [vpv_pkg::VTX_BITS-1:0]   vertex_z,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [vpv_pkg::SCR_BITS-1:0]   screen_x,
    output logic signed [vpv_pkg::SCR_BITS-1:0]   screen_y,
    output logic signed [vpv_pkg::DEPTH_BITS-1:0] depth,
    output logic                                  w_is_zero,
    input  logic                                  cfg_we,
    input  logic [2:0]                            cfg_index,
    input  logic [vpv_pkg::ROW_BITS-1:0]          cfg_data
);
    import vpv_pkg::*;

    localparam int PROD_W = COEF_BITS + VTX_BITS;
    localparam int P_W    = PROD_W + 2;
    localparam int NUM_W  = P_W + 18;
    localparam int NW     = P_W + 1 + QUO_BITS;
    localparam int EXT_W  = 4 * COEF_BITS + ROW_BITS;
    localparam int DIV_LAT = QUO_BITS + 1;
    localparam int DEPTH  = 4 + DIV_LAT;

    localparam logic [ROW_BITS-1:0] RST_ROW_X = 64'h0000_0000_0000_1000;
    localparam logic [ROW_BITS-1:0] RST_ROW_Y = 64'h0000_0000_1000_0000;
    localparam logic [ROW_BITS-1:0] RST_ROW_Z = 64'h0000_1000_0000_0000;
    localparam logic [ROW_BITS-1:0] RST_ROW_W = 64'h1000_0000_0000_0000;
    localparam logic [VIEW_BITS-1:0] RST_VIEW = 13'd500;

    localparam logic [QUO_BITS-1:0] SX_POS = 21'd524287;
    localparam logic [QUO_BITS-1:0] SX_NEG = 21'd524288;
    localparam logic [QUO_BITS-1:0] DZ_POS = 21'd32767;
    localparam logic [QUO_BITS-1:0] DZ_NEG = 21'd32768;

    // ---------------- configuration registers ----------------
    logic [ROW_BITS-1:0]  row_reg [0:3];
    logic [VIEW_BITS-1:0] view_w_reg;
    logic [VIEW_BITS-1:0] view_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= RST_ROW_X;
            row_reg[1] <= RST_ROW_Y;
            row_reg[2] <= RST_ROW_Z;
            row_reg[3] <= RST_ROW_W;
            view_w_reg <= RST_VIEW;
            view_h_reg <= RST_VIEW;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_ROW_X:  row_reg[0] <= cfg_data;
                CFG_ROW_Y:  row_reg[1] <= cfg_data;
                CFG_ROW_Z:  row_reg[2] <= cfg_data;
                CFG_ROW_W:  row_reg[3] <= cfg_data;
                CFG_VIEW_W: view_w_reg <= cfg_data[VIEW_BITS-1:0];
                CFG_VIEW_H: view_h_reg <= cfg_data[VIEW_BITS-1:0];
                default:    ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // Advance every stage together; hold all of them while a word waits.
    logic  en;
    side_t side_reg  [0:DEPTH-1];
    side_t side_next [0:DEPTH-1];
    logic  out_valid_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // ---------------- stage 1: coefficient products ----------------
    logic signed [PROD_W-1:0] prod_reg [0:3][0:3];

    for (genvar r = 0; r < 4; r++)
    begin : g_row
        logic [EXT_W-1:0] ext;
        logic signed [COEF_BITS-1:0] coef [0:3];
        // Bits of a lane above the 64-bit row read as zero.
        assign ext = {{(4 * COEF_BITS){1'b0}}, row_reg[r]};
        for (genvar k = 0; k < 4; k++)
        begin : g_lane
            assign coef[k] = $signed(ext[k * COEF_BITS +: COEF_BITS]);
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                prod_reg[r][0] <= coef[0] * vertex_x;
                prod_reg[r][1] <= coef[1] * vertex_y;
                prod_reg[r][2] <= coef[2] * vertex_z;
                prod_reg[r][3] <= PROD_W'(coef[3]) <<< 12;
            end
        end
    end

    // ---------------- stage 2: row sums ----------------
    logic signed [P_W-1:0] sum_next [0:3];
    logic signed [P_W-1:0] sum_reg  [0:3];

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            sum_next[r] = P_W'(prod_reg[r][0]) + P_W'(prod_reg[r][1])
                        + P_W'(prod_reg[r][2]) + P_W'(prod_reg[r][3]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 4; r++)
            begin
                sum_reg[r] <= sum_next[r];
            end
        end
    end

    // ---------------- stage 3: numerators ----------------
    logic signed [NUM_W-1:0] num_x_reg;
    logic signed [NUM_W-1:0] num_y_reg;
    logic signed [NUM_W-1:0] num_z_reg;
    logic signed [P_W-1:0]   pw_reg;
    logic signed [P_W:0]     sum_xw;
    logic signed [P_W:0]     sum_yw;
    logic signed [P_W+14:0]  mul_x;
    logic signed [P_W+14:0]  mul_y;

    assign sum_xw = (P_W + 1)'(sum_reg[0]) + (P_W + 1)'(sum_reg[3]);
    assign sum_yw = (P_W + 1)'(sum_reg[3]) - (P_W + 1)'(sum_reg[1]);
    assign mul_x  = sum_xw * $signed({1'b0, view_w_reg});
    assign mul_y  = sum_yw * $signed({1'b0, view_h_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Screen scale is 16 for Q16.4 over 2 for the half range.
            num_x_reg <= NUM_W'(mul_x) <<< 3;
            num_y_reg <= NUM_W'(mul_y) <<< 3;
            num_z_reg <= NUM_W'(sum_reg[2]) <<< 12;
            pw_reg    <= sum_reg[3];
        end
    end

    // ---------------- stage 4: magnitudes for rounding ----------------
    // Round to nearest, ties away: q = (2|n| + |d|) / (2|d|).
    logic [NUM_W-1:0] mag_x;
    logic [NUM_W-1:0] mag_y;
    logic [NUM_W-1:0] mag_z;
    logic [P_W-1:0]   mag_w;
    logic [NW-1:0]    dn_x_reg;
    logic [NW-1:0]    dn_y_reg;
    logic [NW-1:0]    dn_z_reg;
    logic [NW-1:0]    dd_reg;

    assign mag_x = num_x_reg[NUM_W-1] ? (NUM_W)'(-num_x_reg) : NUM_W'(num_x_reg);
    assign mag_y = num_y_reg[NUM_W-1] ? (NUM_W)'(-num_y_reg) : NUM_W'(num_y_reg);
    assign mag_z = num_z_reg[NUM_W-1] ? (NUM_W)'(-num_z_reg) : NUM_W'(num_z_reg);
    assign mag_w = pw_reg[P_W-1] ? P_W'(-pw_reg) : P_W'(pw_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dn_x_reg <= (NW'(mag_x) << 1) + NW'(mag_w);
            dn_y_reg <= (NW'(mag_y) << 1) + NW'(mag_w);
            dn_z_reg <= (NW'(mag_z) << 1) + NW'(mag_w);
            dd_reg   <= NW'(mag_w) << 1;
        end
    end

    // ---------------- sideband: valid, zero w, signs ----------------
    always_comb
    begin
        side_next[0]       = '0;
        side_next[0].valid = in_valid;
        for (int i = 1; i < DEPTH; i++)
        begin
            side_next[i] = side_reg[i-1];
        end
        side_next[1].wz    = (sum_next[3] == '0);
        side_next[3].neg_x = num_x_reg[NUM_W-1] ^ pw_reg[P_W-1];
        side_next[3].neg_y = num_y_reg[NUM_W-1] ^ pw_reg[P_W-1];
        side_next[3].neg_z = num_z_reg[NUM_W-1] ^ pw_reg[P_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                side_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                side_reg[i] <= side_next[i];
            end
        end
    end

    // ---------------- dividers ----------------
    logic                ovf_x, ovf_y, ovf_z;
    logic [QUO_BITS-1:0] quo_x, quo_y, quo_z;

    vpv_div #(.NW(NW)) u_div_x (
        .clk (clk), .en (en), .num (dn_x_reg), .den (dd_reg),
        .ovf (ovf_x), .quo (quo_x)
    );

    vpv_div #(.NW(NW)) u_div_y (
        .clk (clk), .en (en), .num (dn_y_reg), .den (dd_reg),
        .ovf (ovf_y), .quo (quo_y)
    );

    vpv_div #(.NW(NW)) u_div_z (
        .clk (clk), .en (en), .num (dn_z_reg), .den (dd_reg),
        .ovf (ovf_z), .quo (quo_z)
    );

    // ---------------- output stage: sign, saturate, zero w ----------------
    function automatic logic [QUO_BITS:0] apply_sat(
        input logic                ovf,
        input logic [QUO_BITS-1:0] q,
        input logic                neg,
        input logic [QUO_BITS-1:0] pos_lim,
        input logic [QUO_BITS-1:0] neg_lim
    );
        logic [QUO_BITS:0] mag;
        mag = {1'b0, q};
        if (neg)
        begin
            if (ovf || q > neg_lim)
            begin
                mag = {1'b0, neg_lim};
            end
            apply_sat = -mag;
        end
        else
        begin
            if (ovf || q > pos_lim)
            begin
                mag = {1'b0, pos_lim};
            end
            apply_sat = mag;
        end
    endfunction

    side_t             last;
    logic [QUO_BITS:0] res_x, res_y, res_z;

    assign last  = side_reg[DEPTH-1];
    assign res_x = apply_sat(ovf_x, quo_x, last.neg_x, SX_POS, SX_NEG);
    assign res_y = apply_sat(ovf_y, quo_y, last.neg_y, SX_POS, SX_NEG);
    assign res_z = apply_sat(ovf_z, quo_z, last.neg_z, DZ_POS, DZ_NEG);

    logic [SCR_BITS-1:0]   sx_reg, sy_reg;
    logic [DEPTH_BITS-1:0] dz_reg;
    logic                  wz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= last.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wz_reg <= last.wz;
            sx_reg <= last.wz ? '0 : res_x[SCR_BITS-1:0];
            sy_reg <= last.wz ? '0 : res_y[SCR_BITS-1:0];
            dz_reg <= last.wz ? '0 : res_z[DEPTH_BITS-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign screen_x  = $signed(sx_reg);
    assign screen_y  = $signed(sy_reg);
    assign depth     = $signed(dz_reg);
    assign w_is_zero = wz_reg;

    // ---------------- assertions ----------------
    a_wz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && w_is_zero) |-> (screen_x == '0 && screen_y == '0 && depth == '0))
        else $error("zero w word carries nonzero coordinates");

    a_stall_block: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input accepted during output stall");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(screen_x) && $stable(screen_y)
                                       && $stable(depth) && $stable(w_is_zero)))
        else $error("output word changed during output stall");

endmodule

>>> hdl/vpv_div.sv
// Pipelined restoring divider: one quotient bit per stage, overflow check up front.
module vpv_div #(
    parameter int NW = 64
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic [NW-1:0]                num,
    input  logic [NW-1:0]                den,
    output logic                         ovf,
    output logic [vpv_pkg::QUO_BITS-1:0] quo
);
    import vpv_pkg::*;

    logic [NW-1:0]       r_reg   [0:QUO_BITS];
    logic [NW-1:0]       d_reg   [0:QUO_BITS];
    logic [QUO_BITS-1:0] q_reg   [0:QUO_BITS];
    logic                ovf_reg [0:QUO_BITS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]   <= num;
            d_reg[0]   <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= (num >= (den << QUO_BITS));
        end
    end

    for (genvar k = 1; k <= QUO_BITS; k++)
    begin : g_step
        localparam int BIT = QUO_BITS - k;
        logic [NW-1:0] trial;
        logic          fits;
        assign trial = d_reg[k-1] << BIT;
        assign fits  = (r_reg[k-1] >= trial);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k]   <= fits ? (r_reg[k-1] - trial) : r_reg[k-1];
                d_reg[k]   <= d_reg[k-1];
                q_reg[k]   <= q_reg[k-1] | (QUO_BITS'(fits) << BIT);
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign ovf = ovf_reg[QUO_BITS];
    assign quo = q_reg[QUO_BITS];

endmodule

>>> bench/vertex_projection_viewport_top_tb.sv
// Self-checking bench for the vertex projection and viewport block.
`timescale 1ns / 1ps

module vertex_projection_viewport_top_tb;
    import vpv_pkg::*;

    localparam int COEF_BITS = 16;
    localparam int LATENCY = 27;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [63:0] ROW_X_RESET = 64'd4096;
    localparam logic [63:0] ROW_Y_RESET = 64'd4096 << 16;
    localparam logic [63:0] ROW_Z_RESET = 64'd4096 << 32;
    localparam logic [63:0] ROW_W_RESET = 64'd4096 << 48;
    localparam logic [2:0] CFG_UNUSED_6 = 3'd6;
    localparam logic [2:0] CFG_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic signed [SCR_BITS-1:0]   sx;
        logic signed [SCR_BITS-1:0]   sy;
        logic signed [DEPTH_BITS-1:0] dz;
        logic                         wz;
    } screen_word_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [VTX_BITS-1:0] vertex_x;
    logic signed [VTX_BITS-1:0] vertex_y;
    logic signed [VTX_BITS-1:0] vertex_z;
    logic out_valid;
    logic out_ready;
    logic signed [SCR_BITS-1:0] screen_x;
    logic signed [SCR_BITS-1:0] screen_y;
    logic signed [DEPTH_BITS-1:0] depth;
    logic w_is_zero;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [ROW_BITS-1:0] cfg_data;

    // Local copy of the configuration that the predictor uses.
    logic [63:0] mat_row [4];
    logic [12:0] vp_width;
    logic [12:0] vp_height;

    screen_word_t expected_pixels[$];
    int errors;
    int vertices_sent;
    int words_checked;
    int idle_cycles;
    bit out_stall_en;   // random stalls on the result side
    bit in_gap_en;      // random gaps on the vertex side
    bit hold_off_req;   // long receiver hold-off
    bit run_done;

    vertex_projection_viewport_top #(.COEF_BITS(COEF_BITS)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_z(vertex_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .screen_x(screen_x), .screen_y(screen_y), .depth(depth),
        .w_is_zero(w_is_zero),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    // Pull one signed coefficient out of a row; bits past 63 read as zero.
    function automatic longint coef_of(logic [63:0] row, int lane);
        longint sh;
        logic [127:0] wide;
        logic [COEF_BITS-1:0] raw;
        sh = lane * COEF_BITS;
        if (sh >= 64)
            return 0;
        wide = {64'd0, row} >> sh;
        raw = wide[COEF_BITS-1:0];
        return longint'($signed(raw));
    endfunction

    // Round to nearest, ties away from zero.
    function automatic longint round_quotient(longint num, longint den);
        bit neg;
        longint un;
        longint ud;
        longint q;
        neg = (num < 0) != (den < 0);
        un = (num < 0) ? -num : num;
        ud = (den < 0) ? -den : den;
        q = (2 * un + ud) / (2 * ud);
        return neg ? -q : q;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic screen_word_t project_vertex(logic signed [15:0] x,
                                                    logic signed [15:0] y,
                                                    logic signed [15:0] z);
        longint v [4];
        longint p [4];
        screen_word_t w;
        v[0] = x;
        v[1] = y;
        v[2] = z;
        v[3] = 4096;
        for (int r = 0; r < 4; r++)
        begin
            p[r] = 0;
            for (int k = 0; k < 4; k++)
                p[r] += coef_of(mat_row[r], k) * v[k];
        end
        w = '0;
        if (p[3] == 0)
        begin
            w.wz = 1'b1;
            return w;
        end
        w.sx = SCR_BITS'(clamp(round_quotient((p[0] + p[3]) * longint'(vp_width) * 8,
                                              p[3]), -524288, 524287));
        w.sy = SCR_BITS'(clamp(round_quotient((p[3] - p[1]) * longint'(vp_height) * 8,
                                              p[3]), -524288, 524287));
        w.dz = DEPTH_BITS'(clamp(round_quotient(p[2] * 4096, p[3]), -32768, 32767));
        return w;
    endfunction

    // ---------------------------------------------------------------
    // Shared stimulus tasks
    // ---------------------------------------------------------------
    // Write one register at an idle moment; unknown indexes are dropped.
    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ROW_X: mat_row[0] = value;
            CFG_ROW_Y: mat_row[1] = value;
            CFG_ROW_Z: mat_row[2] = value;
            CFG_ROW_W: mat_row[3] = value;
            CFG_VIEW_W: vp_width = value[12:0];
            CFG_VIEW_H: vp_height = value[12:0];
            default: ;
        endcase
    endtask

    // Offer one vertex word and hold it until accepted.
    task automatic send_vertex(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        int gap;
        if (in_gap_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        vertex_x <= x;
        vertex_y <= y;
        vertex_z <= z;
        expected_pixels.push_back(project_vertex(x, y, z));
        vertices_sent++;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Wait for the pipeline to drain before touching the registers.
    task automatic drain;
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    function automatic logic [63:0] rand_row;
        return {$urandom, $urandom};
    endfunction

    // Small coefficients keep w away from zero and results mostly in range.
    function automatic logic [63:0] tame_row(int lane_one);
        logic [63:0] r;
        for (int k = 0; k < 4; k++)
            r[k*16 +: 16] = (k == lane_one) ? 16'($urandom_range(2048, 8192))
                                            : 16'($signed($urandom_range(0, 2048)) - 1024);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Result side: stalls, hold-off and checking
    // ---------------------------------------------------------------
    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on %s: got %0d want %0d (word %0d)", what, got, want,
                 words_checked);
        errors++;
    endtask

    initial
    begin
        int stall;
        out_ready = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                // Hold off long enough for the pipeline to back up fully.
                out_ready <= 1'b0;
                for (int c = 0; c < 120; c++)
                    @(negedge clk);
                hold_off_req = 1'b0;
                out_ready <= 1'b1;
            end
            else if (out_stall_en && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 9);
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        screen_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("unexpected result word");
                errors++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (screen_x !== want.sx) report_mismatch("screen_x", screen_x, want.sx);
                if (screen_y !== want.sy) report_mismatch("screen_y", screen_y, want.sy);
                if (depth !== want.dz) report_mismatch("depth", depth, want.dz);
                if (w_is_zero !== want.wz)
                    report_mismatch("w_is_zero", w_is_zero, want.wz);
            end
            words_checked++;
        end
    end

    // Watchdog: count cycles with no handshake on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || run_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired");
            $display("vertex_projection_viewport_top_tb failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Identity matrix, field extremes and viewport corners.
    task automatic test_identity_extremes;
        logic [15:0] ext [5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h1000};
        for (int i = 0; i < 5; i++)
            send_vertex(ext[i], ext[4-i], ext[(i+2)%5]);
        drain();
        write_reg(CFG_VIEW_W, 64'd1);
        write_reg(CFG_VIEW_H, 64'd4096);
        send_vertex(16'h7FFF, 16'h8000, 16'h0800);
        send_vertex(16'h8000, 16'h7FFF, 16'hF800);
        drain();
        // Out-of-range viewport sizes keep only their low 13 bits, zero included.
        write_reg(CFG_VIEW_W, 64'd0);
        write_reg(CFG_VIEW_H, 64'h1FFF);
        send_vertex(16'h1234, 16'hEDCB, 16'h0400);
        drain();
        write_reg(CFG_VIEW_W, 64'hFFFF_FFFF_FFFF_E000);
        write_reg(CFG_VIEW_H, 64'd0);
        send_vertex(16'h0100, 16'h0200, 16'h0300);
        drain();
    endtask

    // Zero w, negative w, and writes to unused indexes.
    task automatic test_w_cases;
        write_reg(CFG_VIEW_W, 64'd640);
        write_reg(CFG_VIEW_H, 64'd480);
        // w row taken from x only: w is zero when x is zero.
        write_reg(CFG_ROW_W, 64'h0000_0000_0000_1000);
        send_vertex(16'h0000, 16'h1000, 16'h2000);
        send_vertex(16'hF000, 16'h0400, 16'h0C00);   // negative w
        send_vertex(16'h0001, 16'h7FFF, 16'h8000);   // tiny w, saturation
        drain();
        write_reg(CFG_UNUSED_6, 64'hDEAD_BEEF_0000_0000);
        write_reg(CFG_UNUSED_7, 64'h1234_5678_9ABC_DEF0);
        send_vertex(16'h1000, 16'h1000, 16'h1000);
        drain();
        // All-ones and all-zero rows cover every coefficient bit.
        write_reg(CFG_ROW_X, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_ROW_Y, 64'h8000_8000_8000_8000);
        write_reg(CFG_ROW_Z, 64'h7FFF_7FFF_7FFF_7FFF);
        write_reg(CFG_ROW_W, 64'h0000_0000_0000_0000);
        send_vertex(16'h5555, 16'hAAAA, 16'h0F0F);
        drain();
        write_reg(CFG_ROW_W, 64'hFFFF_FFFF_FFFF_FFFF);
        send_vertex(16'hAAAA, 16'h5555, 16'hF0F0);
        send_vertex(16'h0000, 16'h0000, 16'h0000);
        drain();
    endtask

    // Random vertices under several matrix and viewport settings.
    task automatic test_random_stream(int count, bit wild);
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
            begin
                drain();
                for (int r = 0; r < 4; r++)
                    write_reg(cfg_index_t'(r), (wild || $urandom_range(0, 4) == 0)
                                                   ? rand_row() : tame_row(r));
                write_reg(CFG_VIEW_W, 64'($urandom_range(1, 4096)));
                write_reg(CFG_VIEW_H, 64'($urandom_range(1, 4096)));
            end
            send_vertex(16'($urandom), 16'($urandom), 16'($urandom));
        end
        drain();
    endtask

    // Back the pipeline up with the receiver held off.
    task automatic test_backpressure;
        hold_off_req = 1'b1;
        for (int i = 0; i < 60; i++)
            send_vertex(16'($urandom), 16'($urandom), 16'($urandom));
        drain();
    endtask

    initial
    begin
        in_valid = 1'b0;
        vertex_x = '0;
        vertex_y = '0;
        vertex_z = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_ROW_X;
        cfg_data = '0;
        errors = 0;
        vertices_sent = 0;
        words_checked = 0;
        idle_cycles = 0;
        out_stall_en = 1'b0;
        in_gap_en = 1'b0;
        hold_off_req = 1'b0;
        run_done = 1'b0;
        mat_row[0] = ROW_X_RESET;
        mat_row[1] = ROW_Y_RESET;
        mat_row[2] = ROW_Z_RESET;
        mat_row[3] = ROW_W_RESET;
        vp_width = 13'd500;
        vp_height = 13'd500;
        rst_n = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_identity_extremes();
        test_w_cases();
        out_stall_en = 1'b1;
        in_gap_en = 1'b1;
        test_random_stream(250, 1'b0);
        test_random_stream(50, 1'b1);
        test_backpressure();
        // Closing stretch: full rate on both sides.
        out_stall_en = 1'b0;
        in_gap_en = 1'b0;
        test_random_stream(50, 1'b0);

        run_done = 1'b1;
        repeat (LATENCY + 10) @(negedge clk);
        $display("covered %0d vertices, %0d result words checked, %0d mismatches",
                 vertices_sent, words_checked, errors);
        $display("identity, extreme fields, zero and negative w, odd viewports, stalls");
        if (errors == 0 && expected_pixels.size() == 0)
            $display("vertex_projection_viewport_top_tb passed");
        else
            $display("vertex_projection_viewport_top_tb failed");
        $finish;
    end

endmodule
